/* sv/b64d_pkg.sv */
package b64d_pkg;

    localparam int ByteW = 8;
    localparam int SextetW = 6;
    localparam int MaxBytes = 3;

    localparam logic [ByteW-1:0] PadChar = 8'h3D;  // '='

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_LENGTH  = 2'd2
    } t_status;

    // Decoded bytes of one request, packed with the first byte in the low bits.
    typedef struct packed {
        logic [1:0]                 count;
        logic [MaxBytes*ByteW-1:0]  bytes;
        t_status                    status;
        logic                       final_flag;
    } t_bundle;

    // Returns {invalid, sextet}; an invalid character yields sextet zero.
    function automatic logic [SextetW:0] sextet_of(input logic [ByteW-1:0] ch);
        logic [ByteW-1:0] d;
        logic [SextetW:0] res;
        res = {1'b1, {SextetW{1'b0}}};
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            d = ch - 8'h41;
            res = {1'b0, d[SextetW-1:0]};
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            d = ch - 8'h61 + 8'd26;
            res = {1'b0, d[SextetW-1:0]};
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
            d = ch - 8'h30 + 8'd52;
            res = {1'b0, d[SextetW-1:0]};
        end else if (ch == 8'h2B || ch == 8'h2D) begin
            res = {1'b0, 6'd62};
        end else if (ch == 8'h2F || ch == 8'h5F) begin
            res = {1'b0, 6'd63};
        end else if (ch == PadChar) begin
            res = {1'b0, 6'd0};
        end
        return res;
    endfunction

endpackage

/* sv/base64_decoder.sv */
// Streaming Base64 decoder. One text character enters per request on the slave side
// (tdata = character, tlast = last character of the text); decoded bytes leave one per
// request on the master side (tdata = byte, tuser = status, tlast = last result).
// Both the standard and URL-safe alphabets are accepted, and '=' counts as zero anywhere.
// A group with an invalid character produces no bytes and latches an error; the final
// character then yields a single result with status 1 (invalid) or 2 (length not a
// multiple of four, which wins), byte zero and tlast set. Characters are taken at one
// per cycle: the first three of a group need no output space and are always accepted,
// and the fourth or a final character waits only until the byte register has room for
// its up to three results. The output side, one byte per cycle while the receiver is ready,
// sets the sustained rate, which keeps up with one character per cycle as four characters
// give at most three bytes. A character's first result appears the cycle after it is taken.
module base64_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] char_in
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] o_m_axis_tuser,   // [1:0] status
    output logic       o_m_axis_tlast
);

    logic              load;
    logic              group_full;
    logic              ser_free;
    b64d_pkg::t_bundle bundle;
    b64d_pkg::t_status status;

    // Characters that cannot produce a result never need the output register.
    assign o_s_axis_tready = ser_free || (!group_full && !i_s_axis_tlast);
    assign load = i_s_axis_tvalid && o_s_axis_tready;

    b64d_group u_group (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_char       (i_s_axis_tdata),
        .i_final      (i_s_axis_tlast),
        .o_group_full (group_full),
        .o_bundle     (bundle)
    );

    b64d_serializer u_ser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_bundle (bundle),
        .o_free   (ser_free),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_byte   (o_m_axis_tdata),
        .o_status (status),
        .o_last   (o_m_axis_tlast)
    );

    assign o_m_axis_tuser = status;

endmodule

/* sv/b64d_group.sv */
module b64d_group (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [b64d_pkg::ByteW-1:0]  i_char,
    input  logic                        i_final,
    output logic                        o_group_full,
    output b64d_pkg::t_bundle           o_bundle
);

    logic [1:0]  r_pos, n_pos;
    logic [17:0] r_acc, n_acc;
    logic        r_third_pad, n_third_pad;
    logic        r_inv, n_inv;
    logic        r_sticky, n_sticky;

    logic [b64d_pkg::SextetW:0] lookup;
    logic                        bad;
    logic [b64d_pkg::SextetW-1:0] sx;
    logic [23:0]                 word;
    logic                        is_pad;

    assign lookup = b64d_pkg::sextet_of(i_char);
    assign bad    = lookup[b64d_pkg::SextetW];
    assign sx     = lookup[b64d_pkg::SextetW-1:0];
    assign word   = {r_acc, sx};
    assign is_pad = (i_char == b64d_pkg::PadChar);
    assign o_group_full = (r_pos == 2'd3);

    always_comb begin
        n_pos       = r_pos;
        n_acc       = r_acc;
        n_third_pad = r_third_pad;
        n_inv       = r_inv;
        n_sticky    = r_sticky;
        o_bundle    = '0;
        o_bundle.status = b64d_pkg::ST_OK;

        if (r_pos != 2'd3) begin
            if (r_pos == 2'd2) begin
                n_third_pad = is_pad;
            end
            n_acc = {r_acc[11:0], sx};
            n_inv = r_inv | bad;
            n_pos = r_pos + 2'd1;
        end else begin
            if (r_inv | bad) begin
                n_sticky = 1'b1;
            end else if (!r_sticky) begin
                // Bytes dropped by padding are squeezed out of the list.
                o_bundle.bytes[7:0]  = word[23:16];
                o_bundle.bytes[15:8] = r_third_pad ? word[7:0] : word[15:8];
                o_bundle.bytes[23:16] = word[7:0];
                o_bundle.count = 2'd1 + {1'b0, !r_third_pad} + {1'b0, !is_pad};
            end
            n_pos       = 2'd0;
            n_acc       = '0;
            n_third_pad = 1'b0;
            n_inv       = 1'b0;
        end

        if (i_final) begin
            if (n_pos != 2'd0) begin
                o_bundle.count  = 2'd1;
                o_bundle.bytes  = '0;
                o_bundle.status = b64d_pkg::ST_LENGTH;
            end else if (n_sticky) begin
                o_bundle.count  = 2'd1;
                o_bundle.bytes  = '0;
                o_bundle.status = b64d_pkg::ST_INVALID;
            end
            o_bundle.final_flag = 1'b1;
            n_pos       = 2'd0;
            n_acc       = '0;
            n_third_pad = 1'b0;
            n_inv       = 1'b0;
            n_sticky    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_acc       <= '0;
            r_third_pad <= 1'b0;
            r_inv       <= 1'b0;
            r_sticky    <= 1'b0;
        end else if (i_load) begin
            r_pos       <= n_pos;
            r_acc       <= n_acc;
            r_third_pad <= n_third_pad;
            r_inv       <= n_inv;
            r_sticky    <= n_sticky;
        end
    end

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load && i_final |=> r_pos == 2'd0 && !r_sticky && !r_inv)
        else $error("decode state not cleared after final character");

    a_final_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load && i_final |-> o_bundle.count != 2'd0)
        else $error("final character produced no result");

endmodule

/* sv/b64d_serializer.sv */
module b64d_serializer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  b64d_pkg::t_bundle           i_bundle,
    output logic                        o_free,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [b64d_pkg::ByteW-1:0]  o_byte,
    output b64d_pkg::t_status           o_status,
    output logic                        o_last
);

    logic              r_valid;
    logic [1:0]        r_idx;
    b64d_pkg::t_bundle r_bundle;
    logic              at_end, take, done;

    assign at_end  = (r_idx == r_bundle.count - 2'd1);
    assign take    = r_valid && i_ready;
    assign done    = take && at_end;
    assign o_free  = !r_valid || done;
    assign o_valid = r_valid;
    assign o_status = r_bundle.status;
    assign o_last   = r_bundle.final_flag && at_end;

    always_comb begin
        case (r_idx)
            2'd0:    o_byte = r_bundle.bytes[7:0];
            2'd1:    o_byte = r_bundle.bytes[15:8];
            2'd2:    o_byte = r_bundle.bytes[23:16];
            default: o_byte = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load && i_bundle.count != 2'd0) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (done) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (take) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_bundle.count != 2'd0) begin
            r_bundle <= i_bundle;
        end
    end

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_idx < r_bundle.count)
        else $error("byte index beyond bundle length");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_bundle.status != b64d_pkg::ST_OK |-> o_last)
        else $error("error result not marked last");

    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && !done && !i_load |=> r_valid && r_idx == $past(r_idx) + 2'd1)
        else $error("byte index did not advance");

endmodule
